// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the bounded stack/queue engine
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define BSQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked property that also holds across reset
`define BSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bsq_pkg.sv -----
// ---------------------------------------------------------------------------
// bsq_pkg
// shared codes, widths and controller/datapath interface structs for the
// bounded stack/queue engine
// ---------------------------------------------------------------------------
`default_nettype none

package bsq_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CODE_W = 3;
   localparam int unsigned SWAP_MIN_ENTRIES = 2;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [CODE_W-1:0] code_type;

   // request codes
   localparam code_type REQ_PUSH  = 3'd0;
   localparam code_type REQ_POP   = 3'd1;
   localparam code_type REQ_SWAP  = 3'd2;
   localparam code_type REQ_PEEK  = 3'd3;
   localparam code_type REQ_PRINT = 3'd4;

   // status codes
   localparam code_type ST_OK         = 3'd0;
   localparam code_type ST_BADARG     = 3'd1;
   localparam code_type ST_PEEK_EMPTY = 3'd2;
   localparam code_type ST_POP_EMPTY  = 3'd3;
   localparam code_type ST_SWAP_SHORT = 3'd4;
   localparam code_type ST_FULL       = 3'd5;

   // read address select
   typedef enum logic [1:0] {
      RD_TOP    = 2'd0,
      RD_SECOND = 2'd1,
      RD_NEXT   = 2'd2
   } rd_sel_type;

   // write address select
   typedef enum logic [1:0] {
      WR_PUSH   = 2'd0,
      WR_TOP    = 2'd1,
      WR_SECOND = 2'd2
   } wr_sel_type;

   // write data source
   typedef enum logic [1:0] {
      SRC_PUSH = 2'd0,
      SRC_READ = 2'd1,
      SRC_HOLD = 2'd2
   } wr_src_type;

   // controller to datapath
   typedef struct packed {
      logic       req_load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      wr_src_type wr_src;
      logic       hold_load;
      logic       push_commit;
      logic       pop_commit;
      logic       k_clear;
      logic       k_inc;
      logic       out_load;
      logic       out_has;
      code_type   out_status;
      logic       out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      code_type op;
      logic     arg_ok;
      logic     empty;
      logic     full;
      logic     short_store;
      logic     k_last;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/bsq_datapath.sv -----
// ---------------------------------------------------------------------------
// bsq_datapath
// ring store, top/count pointers, request and result registers
// ---------------------------------------------------------------------------
`default_nettype none

module bsq_datapath #(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wen,
   input  wire logic                     csr_wdata,
   input  wire bsq_pkg::code_type        in_type,
   input  wire bsq_pkg::data_type        in_value,
   input  wire logic                     in_arg_ok,
   input  wire bsq_pkg::cmd_type         cmd,
   output bsq_pkg::stat_type             stat,
   output bsq_pkg::data_type             out_value,
   output logic                          out_has,
   output bsq_pkg::code_type             out_status,
   output logic                          out_last
);

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = IW + 1;

   // ring slot arithmetic, first operand below depth, second at most depth
   function automatic logic [IW-1:0] ring_add(input logic [SW-1:0] a,
                                              input logic [SW-1:0] b);
      logic [SW-1:0] s;
      s = a + b;
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[IW-1:0];
   endfunction

   bsq_pkg::data_type entry_ff [DEPTH];
   bsq_pkg::data_type rd_data_ff;
   bsq_pkg::data_type hold_ff;

   logic [IW-1:0]     top_ff, top_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [IW-1:0]     ptr_ff;
   logic              push_at_top_ff;

   bsq_pkg::code_type req_type_ff;
   bsq_pkg::data_type push_value_ff;
   logic              arg_ok_ff;

   bsq_pkg::data_type out_value_ff;
   logic              out_has_ff;
   bsq_pkg::code_type out_status_ff;
   logic              out_last_ff;

   logic [IW-1:0]     top_dec;
   logic [IW-1:0]     second_slot;
   logic [IW-1:0]     bottom_slot;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     wr_addr;
   bsq_pkg::data_type wr_data;

   // neighbouring slots of the top, and the slot past the bottom
   assign top_dec     = (top_ff == '0) ? IW'(DEPTH - 1) : top_ff - IW'(1);
   assign second_slot = ring_add({1'b0, top_ff}, SW'(1));
   assign bottom_slot = ring_add({1'b0, top_ff}, SW'(count_ff));

   // read address
   always_comb begin
      case (cmd.rd_sel)
         bsq_pkg::RD_TOP:    rd_addr = top_ff;
         bsq_pkg::RD_SECOND: rd_addr = second_slot;
         bsq_pkg::RD_NEXT:   rd_addr = ring_add({1'b0, ptr_ff}, SW'(1));
         default:            rd_addr = top_ff;
      endcase
   end

   // write address and data
   always_comb begin
      case (cmd.wr_sel)
         bsq_pkg::WR_PUSH:   wr_addr = push_at_top_ff ? top_dec : bottom_slot;
         bsq_pkg::WR_TOP:    wr_addr = top_ff;
         bsq_pkg::WR_SECOND: wr_addr = second_slot;
         default:            wr_addr = top_ff;
      endcase
      case (cmd.wr_src)
         bsq_pkg::SRC_PUSH: wr_data = push_value_ff;
         bsq_pkg::SRC_READ: wr_data = rd_data_ff;
         bsq_pkg::SRC_HOLD: wr_data = hold_ff;
         default:           wr_data = push_value_ff;
      endcase
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   // pointer and counter updates
   always_comb begin
      top_in   = top_ff;
      count_in = count_ff;
      k_in     = k_ff;
      if (cmd.push_commit) begin
         if (push_at_top_ff) begin
            top_in = top_dec;
         end
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_commit) begin
         top_in   = second_slot;
         count_in = count_ff - CW'(1);
      end
      if (cmd.k_clear) begin
         k_in = '0;
      end else if (cmd.k_inc) begin
         k_in = k_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff         <= '0;
         count_ff       <= '0;
         push_at_top_ff <= 1'b1;
      end else begin
         top_ff   <= top_in;
         count_ff <= count_in;
         if (csr_wen) begin
            push_at_top_ff <= csr_wdata;
         end
      end
   end

   // walk pointer, swap hold and request payload
   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.rd_en) begin
         ptr_ff <= rd_addr;
      end
      if (cmd.hold_load) begin
         hold_ff <= rd_data_ff;
      end
      if (cmd.req_load) begin
         req_type_ff   <= in_type;
         push_value_ff <= in_value;
         arg_ok_ff     <= in_arg_ok;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff  <= cmd.out_has ? rd_data_ff : '0;
         out_has_ff    <= cmd.out_has;
         out_status_ff <= cmd.out_status;
         out_last_ff   <= cmd.out_last;
      end
   end

   // status towards the controller
   always_comb begin
      stat.op          = req_type_ff;
      stat.arg_ok      = arg_ok_ff;
      stat.empty       = (count_ff == '0);
      stat.full        = (count_ff == CW'(DEPTH));
      stat.short_store = (count_ff < CW'(bsq_pkg::SWAP_MIN_ENTRIES));
      stat.k_last      = ((k_ff + CW'(1)) == count_ff);
   end

   assign out_value  = out_value_ff;
   assign out_has    = out_has_ff;
   assign out_status = out_status_ff;
   assign out_last   = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bsq_ctrl.sv -----
// ---------------------------------------------------------------------------
// bsq_ctrl
// request sequencer: decode, swap steps, print walk and result handshake
// ---------------------------------------------------------------------------
`default_nettype none

module bsq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire bsq_pkg::stat_type stat,
   output bsq_pkg::cmd_type       cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_SWAP_A = 7'b0000100,
      S_SWAP_B = 7'b0001000,
      S_SWAP_C = 7'b0010000,
      S_EMIT   = 7'b0100000,
      S_PRINT  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic              out_valid_ff, out_valid_in;
   bsq_pkg::code_type status_ff, status_in;
   logic              has_ff, has_in;
   logic              out_free;

   // result slot is free when empty or being taken
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      has_in         = has_ff;
      cmd.req_load   = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.rd_sel     = bsq_pkg::RD_TOP;
      cmd.wr_en      = 1'b0;
      cmd.wr_sel     = bsq_pkg::WR_PUSH;
      cmd.wr_src     = bsq_pkg::SRC_PUSH;
      cmd.hold_load  = 1'b0;
      cmd.push_commit = 1'b0;
      cmd.pop_commit = 1'b0;
      cmd.k_clear    = 1'b0;
      cmd.k_inc      = 1'b0;
      cmd.out_load   = 1'b0;
      cmd.out_has    = 1'b0;
      cmd.out_status = bsq_pkg::ST_OK;
      cmd.out_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = bsq_pkg::ST_OK;
            has_in    = 1'b0;
            state_in  = S_EMIT;
            case (stat.op)
               bsq_pkg::REQ_PUSH: begin
                  if (!stat.arg_ok) begin
                     status_in = bsq_pkg::ST_BADARG;
                  end else if (stat.full) begin
                     status_in = bsq_pkg::ST_FULL;
                  end else begin
                     cmd.wr_en       = 1'b1;
                     cmd.wr_sel      = bsq_pkg::WR_PUSH;
                     cmd.wr_src      = bsq_pkg::SRC_PUSH;
                     cmd.push_commit = 1'b1;
                  end
               end
               bsq_pkg::REQ_POP: begin
                  if (stat.empty) begin
                     status_in = bsq_pkg::ST_POP_EMPTY;
                  end else begin
                     cmd.pop_commit = 1'b1;
                  end
               end
               bsq_pkg::REQ_SWAP: begin
                  if (stat.short_store) begin
                     status_in = bsq_pkg::ST_SWAP_SHORT;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bsq_pkg::RD_TOP;
                     state_in   = S_SWAP_A;
                  end
               end
               bsq_pkg::REQ_PEEK: begin
                  if (stat.empty) begin
                     status_in = bsq_pkg::ST_PEEK_EMPTY;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bsq_pkg::RD_TOP;
                     has_in     = 1'b1;
                  end
               end
               bsq_pkg::REQ_PRINT: begin
                  if (!stat.empty) begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = bsq_pkg::RD_TOP;
                     cmd.k_clear = 1'b1;
                     state_in    = S_PRINT;
                  end
               end
               default: begin
                  status_in = bsq_pkg::ST_OK;
               end
            endcase
         end
         // top entry arrives: keep it, fetch the second
         S_SWAP_A: begin
            cmd.hold_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = bsq_pkg::RD_SECOND;
            state_in      = S_SWAP_B;
         end
         // second entry goes to the top slot
         S_SWAP_B: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bsq_pkg::WR_TOP;
            cmd.wr_src = bsq_pkg::SRC_READ;
            state_in   = S_SWAP_C;
         end
         // old top goes to the second slot
         S_SWAP_C: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bsq_pkg::WR_SECOND;
            cmd.wr_src = bsq_pkg::SRC_HOLD;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_has    = has_ff;
               cmd.out_status = status_ff;
               cmd.out_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         // one entry per free result slot, next read issued alongside
         S_PRINT: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_has    = 1'b1;
               cmd.out_status = bsq_pkg::ST_OK;
               cmd.out_last   = stat.k_last;
               cmd.k_inc      = 1'b1;
               if (stat.k_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = bsq_pkg::RD_NEXT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         status_ff    <= bsq_pkg::ST_OK;
         has_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         status_ff    <= status_in;
         has_ff       <= has_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/bounded_stack_queue_engine.sv -----
// flow: an item is decoded, then results load in the emit or print state; a swap
//   first reads the top, holds it, reads the second and writes both slots; a new item
//   is taken only in idle, once the last result of the one before loads; print-all loads
//   one entry per cycle unless rsp_tready stalls (entry memory has a single read port)
// reset: synchronous; empties the store, selects stack mode, drops rsp_tvalid;
//   entry memory contents are not cleared
// ---------------------------------------------------------------------------
// bounded_stack_queue_engine
// bounded store of signed words driven as a stack or a queue, with push, pop,
// swap, peek and print-all requests and status reporting
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_stack_queue_engine #(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wen,
   input  wire logic        csr_wdata,    // push_at_top
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // [31:0] push_value
   input  wire logic [3:0]  req_tuser,    // [2:0] req_type, [3] arg_ok
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [31:0] out_value
   output logic [3:0]       rsp_tuser,    // [0] has_value, [3:1] status
   output logic             rsp_tlast
);

   bsq_pkg::cmd_type  cmd;
   bsq_pkg::stat_type stat;
   bsq_pkg::data_type out_value;
   logic              out_has;
   bsq_pkg::code_type out_status;

   // sequencer
   bsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // store and result registers
   bsq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .in_type    (req_tuser[2:0]),
      .in_value   (req_tdata),
      .in_arg_ok  (req_tuser[3]),
      .cmd        (cmd),
      .stat       (stat),
      .out_value  (out_value),
      .out_has    (out_has),
      .out_status (out_status),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = out_value;
   assign rsp_tuser = {out_status, out_has};

endmodule

`default_nettype wire

// ----- rtl/core/bsq_checker.sv -----
// ---------------------------------------------------------------------------
// bsq_checker
// port-level checks on the bounded stack/queue engine, bound to the top
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bsq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // a stalled result holds its payload
   `BSQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // a failure result carries no entry and closes its item
   `BSQ_ASSERT(a_fail_shape, clock, reset, rsp_tvalid && (rsp_tuser[3:1] != bsq_pkg::ST_OK) |-> !rsp_tuser[0] && rsp_tlast, "failure result malformed")

   // a result without an entry has zero data
   `BSQ_ASSERT(a_no_value_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0), "data without entry not zero")

   // one item at a time: no accept right after an accept
   `BSQ_ASSERT(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "accepted two items back to back")

   // no result straight out of reset
   `BSQ_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid, "result valid after reset")

endmodule

bind bounded_stack_queue_engine bsq_checker u_bsq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
